FILE: rtl/core/share_rate_difficulty_retarget_core_macros.svh
// assertion helpers for the retarget core
`ifndef SHARE_RATE_DIFFICULTY_RETARGET_CORE_MACROS_SVH
`define SHARE_RATE_DIFFICULTY_RETARGET_CORE_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define SRDR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define SRDR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/srdr_pkg.sv
package srdr_pkg;

    localparam int unsigned WINDOW_DEF = 100;
    localparam int unsigned DIFF_W     = 48;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned CNT_W      = 32;
    localparam int unsigned HASH_W     = 64;
    localparam int unsigned OP_W       = 3;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 48;
    // dividend width of both quotients
    localparam int unsigned NUM_W      = 96;

    typedef enum logic [OP_W-1:0] {
        OP_CONNECT  = 3'd0,
        OP_ACCEPTED = 3'd1,
        OP_REJECTED = 3'd2,
        OP_STALE    = 3'd3,
        OP_TOUCH    = 3'd4,
        OP_SET_DIFF = 3'd5,
        OP_EVALUATE = 3'd6,
        OP_UNUSED   = 3'd7
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE   = 3'd0,
        CFG_INTERVAL = 3'd1,
        CFG_TARGET   = 3'd2,
        CFG_MIN_DIFF = 3'd3,
        CFG_MAX_DIFF = 3'd4,
        CFG_TIMEOUT  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic               start;
        logic [NUM_W-1:0]   dividend;
        logic [TIME_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [NUM_W-1:0]   quotient;
    } t_div_rsp;

    // clamp of a wide value into min then max
    function automatic logic [DIFF_W-1:0] clamp_diff(
        input logic [NUM_W-1:0]  v,
        input logic [DIFF_W-1:0] mn,
        input logic [DIFF_W-1:0] mx
    );
        logic [NUM_W-1:0] t;
        t = v;
        if (t < {{(NUM_W-DIFF_W){1'b0}}, mn}) t = {{(NUM_W-DIFF_W){1'b0}}, mn};
        if (t > {{(NUM_W-DIFF_W){1'b0}}, mx}) t = {{(NUM_W-DIFF_W){1'b0}}, mx};
        return t[DIFF_W-1:0];
    endfunction

endpackage

FILE: rtl/core/srdr_stream_if.sv
interface srdr_stream_if #(
    parameter int unsigned W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/share_rate_difficulty_retarget_core.sv
// channel | dir | payload
// in      | in  | operation, now_seconds, difficulty_value
// out     | out | retarget_due .. hashrate_estimate
// cfg     | in  | i_cfg_we, i_cfg_idx, i_cfg_data
// every item takes two ring reads; when two or more stamps give a positive span,
// two passes of the shared one-bit divider follow, the hashrate pass skipped
// with a zero accepted counter; other items skip both passes.
// in ready is low until the result is taken.
// reset is synchronous; the stamp ring needs no clearing (fill count guards it).
// a stalled result holds in the output register while in ready stays low.
`include "share_rate_difficulty_retarget_core_macros.svh"
module share_rate_difficulty_retarget_core #(
    parameter int unsigned WINDOW = srdr_pkg::WINDOW_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    srdr_stream_if.sink   in_if,
    srdr_stream_if.source out_if,
    input  logic                              i_cfg_we,
    input  logic [srdr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [srdr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    localparam int unsigned AW = $clog2(WINDOW);
    localparam int unsigned FW = $clog2(WINDOW + 1);
    localparam int unsigned SW = 16 + FW;
    localparam int unsigned DFW = srdr_pkg::DIFF_W;
    localparam int unsigned TW = srdr_pkg::TIME_W;
    localparam int unsigned NW = srdr_pkg::NUM_W;
    localparam int unsigned HW = srdr_pkg::HASH_W;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_RD_NEW = 8'b00000010,
        S_RD_OLD = 8'b00000100,
        S_SPAN   = 8'b00001000,
        S_DIV1   = 8'b00010000,
        S_DIV2   = 8'b00100000,
        S_FIN    = 8'b01000000,
        S_OUT    = 8'b10000000
    } t_state;

    t_state r_state;

    // configuration
    logic            r_en;
    logic [15:0]     r_interval, r_target, r_timeout;
    logic [DFW-1:0]  r_min, r_max;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= 1'b1; r_interval <= 16'd90; r_target <= 16'd15;
            r_min <= DFW'(65536); r_max <= '1; r_timeout <= 16'd600;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                srdr_pkg::CFG_ENABLE:   r_en <= i_cfg_data[0];
                srdr_pkg::CFG_INTERVAL: r_interval <= i_cfg_data[15:0];
                srdr_pkg::CFG_TARGET:   r_target <= i_cfg_data[15:0];
                srdr_pkg::CFG_MIN_DIFF: r_min <= i_cfg_data;
                srdr_pkg::CFG_MAX_DIFF: r_max <= i_cfg_data;
                srdr_pkg::CFG_TIMEOUT:  r_timeout <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // input fields
    logic [2:0]     w_op;
    logic [TW-1:0]  w_now;
    logic [DFW-1:0] w_dv;
    assign w_op  = in_if.data[TW+DFW +: 3];
    assign w_now = in_if.data[DFW +: TW];
    assign w_dv  = in_if.data[DFW-1:0];

    // state
    logic [TW-1:0]  mem [WINDOW];
    logic [TW-1:0]  r_rd;
    logic [AW-1:0]  r_head;
    logic [FW-1:0]  r_fill;
    logic [DFW-1:0] r_held;
    logic [31:0]    r_acc, r_rej, r_stl;
    logic [TW-1:0]  r_act, r_ret, r_now, r_newest, r_span;
    logic [SW-1:0]  r_scale;

    logic w_take;
    assign w_take = in_if.valid && in_if.ready;
    assign in_if.ready = (r_state == S_IDLE);

    // ring addresses: newest read in S_RD_NEW, oldest in S_RD_OLD
    logic [AW-1:0] w_newest_a, w_oldest_a, w_rd_a;
    logic [AW:0]   w_tmp;
    always_comb begin
        w_newest_a = (r_head == '0) ? AW'(WINDOW - 1) : r_head - 1'b1;
        w_tmp = {1'b0, r_head} + (AW+1)'(WINDOW) - (AW+1)'(r_fill);
        if (w_tmp >= (AW+1)'(WINDOW)) w_tmp = w_tmp - (AW+1)'(WINDOW);
        w_oldest_a = w_tmp[AW-1:0];
        w_rd_a = (r_state == S_RD_OLD) ? w_oldest_a : w_newest_a;
    end

    always_ff @(posedge i_clk) begin
        if (w_take && srdr_pkg::t_op'(w_op) == srdr_pkg::OP_ACCEPTED) mem[r_head] <= w_now;
        r_rd <= mem[w_rd_a];
    end

    // divider requests
    srdr_pkg::t_div_req w_req;
    srdr_pkg::t_div_rsp w_rsp;
    logic [FW-1:0] w_n1;
    assign w_n1 = r_fill - 1'b1;

    srdr_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    // dividend products, one for each of the two divider requests
    logic [NW-1:0] r_dvd;
    always_comb begin
        w_req.start    = 1'b0;
        w_req.dividend = r_dvd;
        w_req.divisor  = r_span;
        if (r_state == S_SPAN && r_fill >= FW'(2)
            && $signed({1'b0, r_newest}) - $signed({1'b0, r_rd}) > 0) begin
            w_req.start = 1'b1;
            w_req.divisor = r_newest - r_rd;
            w_req.dividend = NW'(r_held) * NW'(r_scale);
        end else if (r_state == S_DIV1 && w_rsp.done && r_acc != '0) begin
            w_req.start = 1'b1;
            w_req.dividend = NW'({r_held, 16'd0}) * NW'(w_n1);
        end
    end

    logic r_due, r_tout;
    logic [DFW-1:0] r_prop;
    logic [HW-1:0]  r_hash;
    logic           r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_head <= '0; r_fill <= '0; r_held <= DFW'(65536);
            r_acc <= '0; r_rej <= '0; r_stl <= '0; r_act <= '0; r_ret <= '0;
            r_ovalid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (w_take) begin
                    r_now <= w_now;
                    case (srdr_pkg::t_op'(w_op))
                        srdr_pkg::OP_CONNECT: begin
                            r_head <= '0; r_fill <= '0; r_acc <= '0; r_rej <= '0;
                            r_stl <= '0; r_held <= w_dv; r_act <= w_now; r_ret <= w_now;
                        end
                        srdr_pkg::OP_ACCEPTED: begin
                            r_acc <= r_acc + 1'b1; r_act <= w_now;
                            r_head <= (r_head == AW'(WINDOW - 1)) ? '0 : r_head + 1'b1;
                            if (r_fill < FW'(WINDOW)) r_fill <= r_fill + 1'b1;
                        end
                        srdr_pkg::OP_REJECTED: begin r_rej <= r_rej + 1'b1; r_act <= w_now; end
                        srdr_pkg::OP_STALE: begin r_stl <= r_stl + 1'b1; r_act <= w_now; end
                        srdr_pkg::OP_TOUCH: r_act <= w_now;
                        srdr_pkg::OP_SET_DIFF: begin
                            r_held <= srdr_pkg::clamp_diff(NW'(w_dv), r_min, r_max);
                            r_ret <= w_now;
                        end
                        default: ;
                    endcase
                    r_state <= S_RD_NEW;
                end
                S_RD_NEW: begin
                    r_scale <= SW'(r_target) * SW'(w_n1);
                    r_state <= S_RD_OLD;
                end
                S_RD_OLD: begin
                    r_newest <= (r_fill == '0) ? '0 : r_rd;
                    r_state <= S_SPAN;
                end
                S_SPAN: begin
                    r_prop <= r_held;
                    r_hash <= '0;
                    r_state <= w_req.start ? S_DIV1 : S_FIN;
                end
                S_DIV1: if (w_rsp.done) begin
                    r_state <= (r_acc != '0) ? S_DIV2 : S_FIN;
                    r_prop <= srdr_pkg::clamp_diff(w_rsp.quotient, r_min, r_max);
                end
                S_DIV2: if (w_rsp.done) begin
                    r_hash <= (w_rsp.quotient[NW-1:HW] != '0) ? '1 : w_rsp.quotient[HW-1:0];
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_due <= r_en && r_fill >= FW'(3) &&
                        $signed({1'b0, r_now}) - $signed({1'b0, r_ret})
                        >= $signed({17'd0, r_interval});
                    r_tout <= $signed({1'b0, r_now}) - $signed({1'b0, r_act})
                        > $signed({17'd0, r_timeout});
                    r_ovalid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: if (out_if.ready) begin
                    r_ovalid <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
        if (w_req.start) r_dvd <= w_req.dividend;
        if (w_req.start) r_span <= w_req.divisor;
    end

    assign out_if.valid = r_ovalid;
    assign out_if.data = {r_due, r_prop, r_held, r_tout, r_acc, r_rej, r_stl,
                          r_newest, r_hash};

    `SRDR_ASSERT_IMP(a_busy_not_ready, i_clk, i_rst_n, r_state != S_IDLE, !in_if.ready)
    `SRDR_ASSERT_IMP(a_out_state, i_clk, i_rst_n, r_ovalid, r_state == S_OUT)
    `SRDR_ASSERT_NXT(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FW'(WINDOW))
endmodule

FILE: rtl/core/srdr_div.sv
// restoring divider, one quotient bit per cycle
module srdr_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  srdr_pkg::t_div_req  i_req,
    output srdr_pkg::t_div_rsp  o_rsp
);
    localparam int unsigned NW = srdr_pkg::NUM_W;
    localparam int unsigned DW = srdr_pkg::TIME_W;
    localparam int unsigned CW = $clog2(NW + 1);

    logic [NW-1:0] r_q, n_q;
    logic [DW:0]   r_rem, n_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy, r_done, n_done;
    logic [DW:0]   w_trial;

    // shift one bit in, trial subtract
    always_comb begin
        w_trial = {r_rem[DW-1:0], r_q[NW-1]};
        n_q     = r_q;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_req.start) begin
            n_q    = i_req.dividend;
            n_rem  = '0;
            n_cnt  = CW'(NW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = w_trial - {1'b0, r_den};
                n_q   = {r_q[NW-2:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_q   = {r_q[NW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        if (i_req.start) r_den <= i_req.divisor;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;
endmodule

FILE: test/srdr_item_pkg.sv
`timescale 1ns / 1ps
package srdr_item_pkg;

    import srdr_pkg::*;

    // one share event as carried on the input channel
    typedef struct packed {
        t_op                op;
        logic [TIME_W-1:0]  now_seconds;
        logic [DIFF_W-1:0]  difficulty_value;
    } t_share_event;

    // one retarget report as carried on the output channel
    typedef struct packed {
        logic               retarget_due;
        logic [DIFF_W-1:0]  proposed_difficulty;
        logic [DIFF_W-1:0]  current_difficulty;
        logic               timed_out;
        logic [CNT_W-1:0]   accepted_total;
        logic [CNT_W-1:0]   rejected_total;
        logic [CNT_W-1:0]   stale_total;
        logic [TIME_W-1:0]  newest_share_time;
        logic [HASH_W-1:0]  hashrate_estimate;
    } t_retarget_report;

    localparam int unsigned EVENT_W  = $bits(t_share_event);
    localparam int unsigned REPORT_W = $bits(t_retarget_report);

endpackage

FILE: test/srdr_report_checker.sv
`timescale 1ns / 1ps
module srdr_report_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    srdr_stream_if in_if,
    srdr_stream_if out_if,
    input  logic                            i_cfg_we,
    input  logic [srdr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [srdr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import srdr_pkg::*;
    import srdr_item_pkg::*;

    localparam int RING_DEPTH = WINDOW_DEF;

    // shadow of the miner state and registers
    logic [TIME_W-1:0] stamps [RING_DEPTH];
    int                head, fill;
    logic [DIFF_W-1:0] held_diff;
    logic [CNT_W-1:0]  acc_cnt, rej_cnt, stale_cnt;
    logic [TIME_W-1:0] last_active, last_retarget;
    logic              vardiff_on;
    logic [15:0]       interval_s, target_s, timeout_s;
    logic [DIFF_W-1:0] diff_floor, diff_ceil;

    t_retarget_report report_q [$];

    function automatic logic [DIFF_W-1:0] bound_diff(logic [127:0] v);
        logic [127:0] t;
        t = v;
        if (t < {80'b0, diff_floor}) t = {80'b0, diff_floor};
        if (t > {80'b0, diff_ceil}) t = {80'b0, diff_ceil};
        return t[DIFF_W-1:0];
    endfunction

    // apply one event and queue the report it must produce
    task automatic apply_event(t_share_event ev);
        t_retarget_report r;
        logic [TIME_W-1:0] now, oldest;
        logic [127:0] wide, scale;
        longint span, d_rt, d_act;
        now = ev.now_seconds;
        case (ev.op)
            OP_CONNECT: begin
                head = 0;
                fill = 0;
                acc_cnt = '0;
                rej_cnt = '0;
                stale_cnt = '0;
                held_diff = ev.difficulty_value;
                last_active = now;
                last_retarget = now;
            end
            OP_ACCEPTED: begin
                acc_cnt++;
                last_active = now;
                stamps[head] = now;
                head = (head + 1) % RING_DEPTH;
                if (fill < RING_DEPTH) fill++;
            end
            OP_REJECTED: begin
                rej_cnt++;
                last_active = now;
            end
            OP_STALE: begin
                stale_cnt++;
                last_active = now;
            end
            OP_TOUCH: last_active = now;
            OP_SET_DIFF: begin
                held_diff = bound_diff({80'b0, ev.difficulty_value});
                last_retarget = now;
            end
            default: ;
        endcase
        r = '0;
        r.proposed_difficulty = held_diff;
        if (fill > 0) r.newest_share_time = stamps[(head + RING_DEPTH - 1) % RING_DEPTH];
        if (fill >= 2) begin
            oldest = stamps[(head + RING_DEPTH - fill) % RING_DEPTH];
            span = longint'({32'b0, r.newest_share_time}) - longint'({32'b0, oldest});
            if (span > 0) begin
                scale = 128'(target_s) * 128'(fill - 1);
                wide = (128'(held_diff) * scale) / 128'(span);
                r.proposed_difficulty = bound_diff(wide);
                if (acc_cnt != 0) begin
                    wide = (128'(held_diff) * (128'(fill - 1) << 16)) / 128'(span);
                    r.hashrate_estimate = (wide[127:64] != 0) ? '1 : wide[63:0];
                end
            end
        end
        d_rt = longint'({32'b0, now}) - longint'({32'b0, last_retarget});
        d_act = longint'({32'b0, now}) - longint'({32'b0, last_active});
        r.retarget_due = vardiff_on && fill >= 3 && d_rt >= longint'(interval_s);
        r.timed_out = d_act > longint'(timeout_s);
        r.current_difficulty = held_diff;
        r.accepted_total = acc_cnt;
        r.rejected_total = rej_cnt;
        r.stale_total = stale_cnt;
        report_q = {report_q, r};
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            o_fail_count++;
        end
    endtask

    // compare the oldest expected report with each one taken
    task automatic compare_report(t_retarget_report got);
        t_retarget_report want;
        if (report_q.size() == 0) begin
            $error("report: none expected, got one");
            o_fail_count++;
            return;
        end
        want = report_q.pop_front();
        check_field("retarget_due", want.retarget_due, got.retarget_due);
        check_field("proposed_difficulty", want.proposed_difficulty,
                    got.proposed_difficulty);
        check_field("current_difficulty", want.current_difficulty,
                    got.current_difficulty);
        check_field("timed_out", want.timed_out, got.timed_out);
        check_field("accepted_total", want.accepted_total, got.accepted_total);
        check_field("rejected_total", want.rejected_total, got.rejected_total);
        check_field("stale_total", want.stale_total, got.stale_total);
        check_field("newest_share_time", want.newest_share_time,
                    got.newest_share_time);
        check_field("hashrate_estimate", want.hashrate_estimate,
                    got.hashrate_estimate);
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head = 0;
            fill = 0;
            held_diff = 48'd65536;
            acc_cnt = '0;
            rej_cnt = '0;
            stale_cnt = '0;
            last_active = '0;
            last_retarget = '0;
            vardiff_on = 1'b1;
            interval_s = 16'd90;
            target_s = 16'd15;
            diff_floor = 48'd65536;
            diff_ceil = '1;
            timeout_s = 16'd600;
            report_q.delete();
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ENABLE:   vardiff_on = i_cfg_data[0];
                    CFG_INTERVAL: interval_s = i_cfg_data[15:0];
                    CFG_TARGET:   target_s = i_cfg_data[15:0];
                    CFG_MIN_DIFF: diff_floor = i_cfg_data;
                    CFG_MAX_DIFF: diff_ceil = i_cfg_data;
                    CFG_TIMEOUT:  timeout_s = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (out_if.valid && out_if.ready) compare_report(t_retarget_report'(out_if.data));
            if (in_if.valid && in_if.ready) apply_event(t_share_event'(in_if.data));
        end
        o_pending = report_q.size();
    end

endmodule

FILE: test/share_rate_difficulty_retarget_core_test.sv
`timescale 1ns / 1ps
module share_rate_difficulty_retarget_core_test;
    import srdr_pkg::*;
    import srdr_item_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int fail_count, pending;

    srdr_stream_if #(.W(EVENT_W))  in_if ();
    srdr_stream_if #(.W(REPORT_W)) out_if ();

    share_rate_difficulty_retarget_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_if      (in_if),
        .out_if     (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    srdr_report_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_if        (in_if),
        .out_if       (out_if),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 2 ns clock
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver stalls in runs, with stretches of steady ready
    int stall_mode;
    initial begin
        out_if.ready = 1'b0;
        stall_mode = 0;
    end
    always @(negedge i_clk) begin
        if ($urandom_range(199) == 0) stall_mode = $urandom_range(2);
        case (stall_mode)
            0: out_if.ready <= 1'b1;
            1: out_if.ready <= ($urandom_range(3) != 0);
            default: out_if.ready <= ($urandom_range(9) == 0);
        endcase
    end

    int burst_left;
    logic [TIME_W-1:0] clock_s;

    // hand one event to the block, with gaps between bursts
    task automatic send_event(t_op op, logic [TIME_W-1:0] now, logic [DIFF_W-1:0] dv);
        t_share_event ev;
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        ev.op = op;
        ev.now_seconds = now;
        ev.difficulty_value = dv;
        in_if.valid <= 1'b1;
        in_if.data <= ev;
        forever begin
            @(posedge i_clk);
            if (in_if.ready) break;
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(logic en, logic [15:0] intv, logic [15:0] tgt,
                             logic [47:0] mn, logic [47:0] mx, logic [15:0] tmo);
        write_reg(CFG_ENABLE, {47'b0, en});
        write_reg(CFG_INTERVAL, {32'b0, intv});
        write_reg(CFG_TARGET, {32'b0, tgt});
        write_reg(CFG_MIN_DIFF, mn);
        write_reg(CFG_MAX_DIFF, mx);
        write_reg(CFG_TIMEOUT, {32'b0, tmo});
    endtask

    function automatic logic [DIFF_W-1:0] pick_diff();
        case ($urandom_range(3))
            0: return 48'({$urandom, $urandom});
            1: return 48'd65536 << $urandom_range(0, 20);
            2: return 48'($urandom_range(0, 1 << 20)) << 10;
            default: return 48'd65536 + $urandom_range(0, 65535);
        endcase
    endfunction

    // random event mix: mostly accepted shares on a moving clock
    task automatic random_event();
        int r;
        t_op op;
        r = $urandom_range(99);
        if (r < 2) op = OP_CONNECT;
        else if (r < 60) op = OP_ACCEPTED;
        else if (r < 67) op = OP_REJECTED;
        else if (r < 72) op = OP_STALE;
        else if (r < 77) op = OP_TOUCH;
        else if (r < 83) op = OP_SET_DIFF;
        else if (r < 97) op = OP_EVALUATE;
        else op = OP_UNUSED;
        r = $urandom_range(99);
        if (r < 85) clock_s += $urandom_range(0, 30);
        else if (r < 93) clock_s += $urandom_range(0, 2000);
        else if (r < 97) clock_s -= $urandom_range(1, 100);
        else clock_s = $urandom;
        send_event(op, clock_s, pick_diff());
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.data = '0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        burst_left = 0;
        clock_s = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every operation, special cases
        send_event(OP_EVALUATE, 32'd0, '0);
        send_event(OP_CONNECT, 32'd0, '1);
        send_event(OP_ACCEPTED, 32'd1, '0);
        send_event(OP_ACCEPTED, 32'd4, '0);
        send_event(OP_ACCEPTED, 32'd9, '0);
        send_event(OP_EVALUATE, 32'd200, '0);
        send_event(OP_UNUSED, 32'd900, '0);
        send_event(OP_REJECTED, 32'd901, '0);
        send_event(OP_STALE, 32'd902, '0);
        send_event(OP_TOUCH, 32'd903, '0);
        send_event(OP_SET_DIFF, 32'd904, '0);
        send_event(OP_SET_DIFF, 32'd905, '1);
        send_event(OP_EVALUATE, 32'd100, '0);
        send_event(OP_CONNECT, 32'hFFFF_FFFF, '0);
        send_event(OP_ACCEPTED, 32'hFFFF_FFFF, '0);
        send_event(OP_ACCEPTED, 32'hFFFF_FFFF, '0);
        send_event(OP_EVALUATE, 32'hFFFF_FFFF, '0);
        send_event(OP_CONNECT, 32'd50, 48'h5555_5555_5555);
        send_event(OP_ACCEPTED, 32'd51, '0);
        send_event(OP_ACCEPTED, 32'd52, '0);
        send_event(OP_ACCEPTED, 32'd53, '0);
        send_event(OP_EVALUATE, 32'd10, '0);
        send_event(OP_CONNECT, 32'd20, 48'hAAAA_AAAA_AAAA);
        clock_s = 32'd20;

        // random phases under several register settings
        for (int ph = 0; ph < 6; ph++) begin
            wait_drained();
            case (ph)
                0: write_all(1'b1, 16'd90, 16'd15, 48'd65536, '1, 16'd600);
                1: write_all(1'b0, 16'd0, 16'd1, '0, '1, 16'd0);
                2: write_all(1'b1, 16'd0, 16'hFFFF, 48'd65536, '1, 16'hFFFF);
                3: write_all(1'b1, 16'hFFFF, 16'd0, 48'd1 << 40, 48'd1 << 20, 16'd60);
                4: write_all(1'b1, 16'd30, 16'd10, 48'd65536, 48'd1 << 36, 16'd120);
                default: write_all(1'b1, 16'hAAAA, 16'h5555, 48'hAAAA_AAAA_AAAA,
                                   48'h5555_5555_5555, 16'h5555);
            endcase
            for (int k = 0; k < 315; k++) random_event();
        end

        wait_drained();
        repeat (300) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
